// File: rtl/htrf_pkg.sv
// ----------------------------------------------------------------------------
// htrf_pkg: shared constants and types of the Hall tachometer speed filter
// Field widths, ring geometry, register indexes, reset values, divider sizing and sequencer states.
// ----------------------------------------------------------------------------
package htrf_pkg;

  // capture and speed fields
  localparam int CAPTURE_BITS = 32;
  localparam int CAPIN_W      = 32;
  localparam int SPEED_W      = 24;
  localparam int FACT_W       = 4;
  localparam int LIM_W        = SPEED_W + FACT_W;

  // speed ring
  localparam int RING_DEPTH   = 64;
  localparam int IDX_W        = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W        = $clog2(RING_DEPTH + 1);
  localparam int SUM_W        = SPEED_W + IDX_W;

  // shared bit-serial divider: dividend shift register and step counter
  localparam int DIV_W        = (SUM_W > SPEED_W) ? SUM_W : SPEED_W;
  localparam int DCNT_W       = $clog2(DIV_W);

  // configuration port
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 24;

  localparam logic [CFG_IDX_W-1:0] REG_RPM_CONSTANT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_FACTOR = CFG_IDX_W'(1);

  localparam logic [SPEED_W-1:0] RPM_CONSTANT_RST  = SPEED_W'(600000);
  localparam logic [FACT_W-1:0]  FILTER_FACTOR_RST = FACT_W'(3);

  // sequencer states
  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_DIFF  = 10'b00_0000_0010,
    S_DSPD  = 10'b00_0000_0100,
    S_RDP   = 10'b00_0000_1000,
    S_RDC   = 10'b00_0001_0000,
    S_MUL   = 10'b00_0010_0000,
    S_WR    = 10'b00_0100_0000,
    S_MLD   = 10'b00_1000_0000,
    S_DMEAN = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_t;

endpackage

// File: rtl/htrf_if.sv
// ----------------------------------------------------------------------------
// htrf_if: request channels of the Hall tachometer speed filter
// Capture input, speed result and register write channels with valid/ready.
// ----------------------------------------------------------------------------

// capture input channel
interface htrf_in_if import htrf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CAPIN_W-1:0] capture_value;
  logic               motor_on;

  modport source (output valid, capture_value, motor_on, input ready);
  modport sink   (input valid, capture_value, motor_on, output ready);
endinterface

// speed result channel
interface htrf_out_if import htrf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               edge_valid;
  logic [SPEED_W-1:0] rpm_instant;
  logic               sample_stored;
  logic [SPEED_W-1:0] rpm_mean;

  modport source (output valid, edge_valid, rpm_instant, sample_stored, rpm_mean,
                  input ready);
  modport sink   (input valid, edge_valid, rpm_instant, sample_stored, rpm_mean,
                  output ready);
endinterface

// register write channel
interface htrf_cfg_if import htrf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// File: rtl/hall_tachometer_rpm_filter_unit.sv
// ----------------------------------------------------------------------------
// hall_tachometer_rpm_filter_unit: Hall capture tachometer with filtered mean
// Turns capture timestamps into an instant speed and a ring-averaged speed.
// ----------------------------------------------------------------------------
// Usage
//   in_ch  : one request per Hall edge, a timer capture and the motor-on flag.
//   out_ch : one request per input: edge_valid, rpm_instant, sample_stored and
//            rpm_mean.
//   cfg_ch : register writes (index 0 rpm_constant, 1 filter_factor), always
//            ready; other indexes are ignored. Write only while the unit idles.
// Timing
//   One request is worked on at a time. A valid edge runs the speed division,
//   two ring reads and a ring update; an invalid edge goes straight on to the
//   mean division. The mean division is skipped when the motor is off or the
//   ring holds no speed. The next request can be taken in the cycle after the
//   result is loaded. Both divisions run on one shared restoring divider that
//   retires a single quotient bit per cycle; the ring is a memory read twice
//   per edge.
// Reset and stalls
//   rst_n clears the ring (by per-slot valid bits), the index, the sum, the
//   count and loads the register defaults; the previous capture resets to 1.
//   A finished result waits in the output register; the next capture is still
//   taken, and its result is held back until the receiver takes the first.
// ----------------------------------------------------------------------------
module hall_tachometer_rpm_filter_unit import htrf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  htrf_cfg_if.sink    cfg_ch,
  htrf_in_if.sink     in_ch,
  htrf_out_if.source  out_ch
);

  // configuration registers
  logic [SPEED_W-1:0]      rpm_constant_r;
  logic [FACT_W-1:0]       filter_factor_r;

  // architectural state
  state_t                  state_r;
  logic [CAPTURE_BITS-1:0] prev_cap_r;
  logic [SPEED_W-1:0]      last_speed_r;
  logic [IDX_W-1:0]        idx_r;
  logic [SUM_W-1:0]        sum_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [RING_DEPTH-1:0]   slot_vld_r;

  // per-request working registers
  logic [CAPTURE_BITS-1:0] cap_r;
  logic                    on_r;
  logic                    edge_ok_r;
  logic                    stored_r;
  logic [SPEED_W-1:0]      prev_val_r;
  logic [SPEED_W-1:0]      cur_val_r;
  logic [LIM_W-1:0]        limit_r;
  logic [SPEED_W-1:0]      mean_r;

  // shared divider
  logic [DIV_W-1:0]        q_r;
  logic [CAPTURE_BITS-1:0] rem_r;
  logic [CAPTURE_BITS-1:0] dsr_r;
  logic [DCNT_W-1:0]       dcnt_r;
  logic [CAPTURE_BITS:0]   div_trial;
  logic                    div_ge;
  logic [CAPTURE_BITS:0]   div_diff;
  logic [CAPTURE_BITS-1:0] rem_nxt;
  logic [DIV_W-1:0]        q_nxt;

  // speed ring memory
  logic [SPEED_W-1:0]      ring_mem [RING_DEPTH];
  logic [SPEED_W-1:0]      rd_data_r;
  logic                    rd_vld_r;
  logic [IDX_W-1:0]        rd_addr;
  logic [IDX_W-1:0]        prev_idx;
  logic [IDX_W-1:0]        idx_nxt;

  // output register
  logic                    out_valid_r;
  logic                    out_edge_r;
  logic [SPEED_W-1:0]      out_inst_r;
  logic                    out_stored_r;
  logic [SPEED_W-1:0]      out_mean_r;

  // filter decision and ring bookkeeping
  logic [SPEED_W-1:0]      speed;
  logic                    store_ok;
  logic [SUM_W-1:0]        sum_nxt;
  logic [CNT_W-1:0]        cnt_nxt;
  logic [CAPTURE_BITS-1:0] abs_diff;
  logic                    in_acc;
  logic                    out_load;

  // handshakes
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_load     = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid         = out_valid_r;
  assign out_ch.edge_valid    = out_edge_r;
  assign out_ch.rpm_instant   = out_inst_r;
  assign out_ch.sample_stored = out_stored_r;
  assign out_ch.rpm_mean      = out_mean_r;

  // absolute capture difference
  assign abs_diff = (cap_r > prev_cap_r) ? (cap_r - prev_cap_r) : (prev_cap_r - cap_r);

  // restoring divider step: one quotient bit per cycle
  assign div_trial = {rem_r, q_r[DIV_W-1]};
  assign div_ge    = (div_trial >= {1'b0, dsr_r});
  assign div_diff  = div_trial - {1'b0, dsr_r};
  assign rem_nxt   = div_ge ? div_diff[CAPTURE_BITS-1:0] : div_trial[CAPTURE_BITS-1:0];
  assign q_nxt     = {q_r[DIV_W-2:0], div_ge};

  // ring index neighbours
  assign prev_idx = (idx_r == '0) ? IDX_W'(RING_DEPTH - 1) : idx_r - IDX_W'(1);
  assign idx_nxt  = (idx_r == IDX_W'(RING_DEPTH - 1)) ? '0 : idx_r + IDX_W'(1);
  assign rd_addr  = (state_r == S_RDP) ? prev_idx : idx_r;

  // filter test and running sum/count after a write
  assign speed    = q_r[SPEED_W-1:0];
  assign store_ok = ({{FACT_W{1'b0}}, speed} < limit_r) || (cur_val_r == '0);
  assign sum_nxt  = sum_r - {{IDX_W{1'b0}}, cur_val_r} + {{IDX_W{1'b0}}, speed};
  assign cnt_nxt  = cnt_r - CNT_W'(cur_val_r != '0) + CNT_W'(speed != '0);

  // control state and architectural registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      rpm_constant_r  <= RPM_CONSTANT_RST;
      filter_factor_r <= FILTER_FACTOR_RST;
      prev_cap_r      <= CAPTURE_BITS'(1);
      last_speed_r    <= '0;
      idx_r           <= '0;
      sum_r           <= '0;
      cnt_r           <= '0;
      slot_vld_r      <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      // register writes
      if (cfg_ch.valid) begin
        unique case (cfg_ch.reg_index)
          REG_RPM_CONSTANT:  rpm_constant_r  <= cfg_ch.wdata[SPEED_W-1:0];
          REG_FILTER_FACTOR: filter_factor_r <= cfg_ch.wdata[FACT_W-1:0];
          default: ;
        endcase
      end

      // output register
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      // sequencer
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_DIFF;
          end
        end
        S_DIFF: begin
          prev_cap_r <= cap_r;
          if ((prev_cap_r != '0) && (cap_r != prev_cap_r)) begin
            state_r <= S_DSPD;
          end else begin
            state_r <= S_MLD;
          end
        end
        S_DSPD: begin
          if (dcnt_r == '0) begin
            state_r <= S_RDP;
          end
        end
        S_RDP: state_r <= S_RDC;
        S_RDC: state_r <= S_MUL;
        S_MUL: state_r <= S_WR;
        S_WR: begin
          last_speed_r <= speed;
          idx_r        <= idx_nxt;
          if (store_ok) begin
            slot_vld_r[idx_r] <= 1'b1;
            sum_r             <= sum_nxt;
            cnt_r             <= cnt_nxt;
          end
          state_r <= S_MLD;
        end
        S_MLD: begin
          if (on_r && (cnt_r != '0)) begin
            state_r <= S_DMEAN;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DMEAN: begin
          if (dcnt_r == '0) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // capture request
    if (in_acc) begin
      cap_r    <= in_ch.capture_value[CAPTURE_BITS-1:0];
      on_r     <= in_ch.motor_on;
      stored_r <= 1'b0;
    end

    // edge check and speed division load
    if (state_r == S_DIFF) begin
      edge_ok_r <= (prev_cap_r != '0) && (cap_r != prev_cap_r);
      dsr_r     <= abs_diff;
      q_r       <= DIV_W'(rpm_constant_r);
      rem_r     <= '0;
      dcnt_r    <= DCNT_W'(DIV_W - 1);
    end

    // divider steps
    if ((state_r == S_DSPD) || (state_r == S_DMEAN)) begin
      q_r    <= q_nxt;
      rem_r  <= rem_nxt;
      dcnt_r <= dcnt_r - DCNT_W'(1);
    end

    // ring reads: previous slot, then current slot
    if (state_r == S_RDC) begin
      prev_val_r <= rd_vld_r ? rd_data_r : '0;
    end
    if (state_r == S_MUL) begin
      cur_val_r <= rd_vld_r ? rd_data_r : '0;
      limit_r   <= LIM_W'(filter_factor_r) * LIM_W'(prev_val_r);
    end
    if (state_r == S_WR) begin
      stored_r <= store_ok;
    end

    // mean division load
    if (state_r == S_MLD) begin
      mean_r <= '0;
      q_r    <= DIV_W'(sum_r);
      dsr_r  <= CAPTURE_BITS'(cnt_r);
      rem_r  <= '0;
      dcnt_r <= DCNT_W'(DIV_W - 1);
    end
    if ((state_r == S_DMEAN) && (dcnt_r == '0)) begin
      mean_r <= q_nxt[SPEED_W-1:0];
    end

    // result
    if (out_load) begin
      out_edge_r   <= edge_ok_r;
      out_inst_r   <= last_speed_r;
      out_stored_r <= stored_r;
      out_mean_r   <= mean_r;
    end
  end

  // speed ring: one write port, one registered read port
  always_ff @(posedge clk) begin
    if ((state_r == S_WR) && store_ok) begin
      ring_mem[idx_r] <= speed;
    end
    rd_data_r <= ring_mem[rd_addr];
  end

  // slot valid flag follows the read address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= slot_vld_r[rd_addr];
    end
  end

endmodule

// File: bench/hall_tachometer_rpm_filter_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hall_tachometer_rpm_filter_unit_tb: self-checking bench for the tachometer
// Sends Hall capture requests and register writes, with random idling on both
// sides. A local predictor keeps its own ring, sum and count and works out
// every speed result, which is compared field by field as it comes out.
// ----------------------------------------------------------------------------
module hall_tachometer_rpm_filter_unit_tb;
  import htrf_pkg::*;

  localparam int IDLE_PCT    = 28;
  localparam int REPORT_MAX  = 10;
  localparam int TAIL_CYCLES = 2 * DIV_W + 20;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 200;

  // indexes outside the register list, written to show they are ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_TOP = '1;

  typedef struct packed {
    logic               edge_valid;
    logic [SPEED_W-1:0] rpm_instant;
    logic               sample_stored;
    logic [SPEED_W-1:0] rpm_mean;
  } speed_result_t;

  logic clk;
  logic rst_n;

  htrf_in_if  in_if ();
  htrf_out_if out_if ();
  htrf_cfg_if cfg_if ();

  hall_tachometer_rpm_filter_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_if),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // predictor copy of the registers and the filter state
  logic [SPEED_W-1:0]      rpm_const;
  logic [FACT_W-1:0]       filt_factor;
  logic [CAPTURE_BITS-1:0] prev_capture;
  logic [SPEED_W-1:0]      held_speed;
  logic [SPEED_W-1:0]      speed_ring [RING_DEPTH];
  logic [IDX_W-1:0]        ring_idx;
  logic [SUM_W-1:0]        ring_sum;
  logic [CNT_W-1:0]        nonzero_cnt;

  speed_result_t      speed_q [$];
  speed_result_t      got;
  speed_result_t      want;
  int                 fault_count;
  bit                 calm;
  logic [CAPIN_W-1:0] cur_cap;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop if the run hangs
  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // speed for one capture, updating the ring as the unit should
  function automatic speed_result_t predict_speed(input logic [CAPIN_W-1:0] cap_in,
                                                  input logic on);
    speed_result_t           r;
    logic [CAPTURE_BITS-1:0] cap;
    logic [CAPTURE_BITS-1:0] old;
    logic [CAPTURE_BITS-1:0] diff;
    logic [SPEED_W-1:0]      spd;
    logic [IDX_W-1:0]        back;
    logic [LIM_W-1:0]        ceiling;
    r    = '0;
    cap  = CAPTURE_BITS'(cap_in);
    old  = prev_capture;
    r.edge_valid = (old != '0) && (cap != old);
    prev_capture = cap;
    if (r.edge_valid) begin
      // absolute interval, so a timer wrap reads as a long interval
      diff = (cap > old) ? cap - old : old - cap;
      spd  = SPEED_W'(rpm_const / diff);
      // slot before index zero is the last slot
      back = (ring_idx == '0) ? IDX_W'(RING_DEPTH - 1) : ring_idx - IDX_W'(1);
      ceiling = LIM_W'(filt_factor) * LIM_W'(speed_ring[back]);
      held_speed = spd;
      if (LIM_W'(spd) < ceiling || speed_ring[ring_idx] == '0) begin
        ring_sum = ring_sum - SUM_W'(speed_ring[ring_idx]) + SUM_W'(spd);
        if (speed_ring[ring_idx] != '0) nonzero_cnt = nonzero_cnt - CNT_W'(1);
        if (spd != '0) nonzero_cnt = nonzero_cnt + CNT_W'(1);
        speed_ring[ring_idx] = spd;
        r.sample_stored = 1'b1;
      end
      ring_idx = (ring_idx == IDX_W'(RING_DEPTH - 1)) ? '0 : ring_idx + IDX_W'(1);
    end
    r.rpm_instant = held_speed;
    if (on && nonzero_cnt != '0) r.rpm_mean = SPEED_W'(ring_sum / nonzero_cnt);
    return r;
  endfunction

  // one capture request, with an optional idle gap in front
  task automatic send_capture(input logic [CAPIN_W-1:0] cap, input logic on);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 80)) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.capture_value <= cap;
    in_if.motor_on      <= on;
    do @(posedge clk); while (!in_if.ready);
    speed_q.push_back(predict_speed(cap, on));
    cur_cap = cap;
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (speed_q.size() != 0) @(posedge clk);
  endtask

  // one register write request; valid is left high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= data;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_RPM_CONSTANT:  rpm_const   = SPEED_W'(data);
      REG_FILTER_FACTOR: filt_factor = data[FACT_W-1:0];
      default: ;
    endcase
  endtask

  // new register setting once the unit is idle, plus writes to unused indexes
  task automatic configure(input logic [SPEED_W-1:0] speed_k,
                           input logic [FACT_W-1:0] factor);
    logic [CFG_DATA_W-1:0] factor_word;
    // upper bits of the factor word are junk and must be dropped
    factor_word = CFG_DATA_W'($urandom);
    factor_word[FACT_W-1:0] = factor;
    drain();
    write_reg(REG_RPM_CONSTANT, CFG_DATA_W'(speed_k));
    write_reg(REG_FILTER_FACTOR, factor_word);
    write_reg(REG_SPARE_LOW, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_TOP, '1);
    cfg_if.valid <= 1'b0;
  endtask

  // edge validity rules under the reset register values
  task automatic test_edge_validity();
    // same as the reset previous capture: no edge
    send_capture(32'd1, 1'b1);
    // one tick: full constant into the empty first slot
    send_capture(32'd0, 1'b1);
    // previous capture zero: no edge
    send_capture(32'd5, 1'b1);
    // interval beyond the constant gives zero speed; motor off
    send_capture(32'hFFFF_FFFF, 1'b0);
    // repeated capture
    send_capture(32'hFFFF_FFFF, 1'b1);
    // timer ran backwards
    send_capture(32'h7FFF_FFFF, 1'b1);
    send_capture(32'h8000_03E7, 1'b1);
    send_capture(32'h8000_0BB7, 1'b1);
  endtask

  // register extremes, including zero constant and zero factor
  task automatic test_register_extremes();
    configure('1, 4'd15);
    send_capture(cur_cap + 32'd1, 1'b1);
    send_capture(cur_cap + 32'h00FF_FFFF, 1'b1);
    send_capture(cur_cap + 32'h0100_0000, 1'b1);
    configure('0, 4'd0);
    send_capture(cur_cap + 32'd1, 1'b1);
    send_capture(cur_cap + 32'd1000, 1'b0);
    configure(24'd1, 4'd1);
    send_capture(cur_cap + 32'd1, 1'b1);
    send_capture(cur_cap + 32'd2, 1'b1);
  endtask

  // steady rotation with jitter, spikes, stalls and junk over several settings
  task automatic test_filtered_mean();
    logic [SPEED_W-1:0] const_tab [PHASES];
    logic [FACT_W-1:0]  fact_tab  [PHASES];
    logic [CAPIN_W-1:0] period;
    logic [CAPIN_W-1:0] step;
    logic [CAPIN_W-1:0] cap;
    int                 pick;
    const_tab = '{24'd600000, 24'hFFFFFF, 24'd1, 24'd0,
                  24'd600000, 24'd3000000, 24'd150000, 24'd600000};
    fact_tab  = '{4'd15, 4'd1, 4'd7, 4'd5, 4'd0, 4'd2, 4'd3, 4'd3};
    const_tab[6] = SPEED_W'($urandom_range(1, 24'hFFFFFF));
    fact_tab[6]  = FACT_W'($urandom_range(1, 15));
    for (int ph = 0; ph < PHASES; ph++) begin
      configure(const_tab[ph], fact_tab[ph]);
      // last phase runs without any idling
      calm = (ph == PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // fresh nominal period now and then, so the filter sees big steps
        if (n % 50 == 0) begin
          if (rpm_const < 100) period = $urandom_range(1, 4000);
          else period = rpm_const / $urandom_range(30, 30000);
          if (period == '0) period = 1;
        end
        pick = $urandom_range(99);
        if (pick < 70) begin
          step = period + $urandom_range(0, period / 8) - period / 16;
          if (step == '0) step = 1;
          cap = cur_cap + step;
        end else if (pick < 78) begin
          // sudden fast edge, likely rejected once the ring is full
          step = period / $urandom_range(2, 20);
          if (step == '0) step = 1;
          cap = cur_cap + step;
        end else if (pick < 84) begin
          cap = cur_cap + period * $urandom_range(2, 40);
        end else if (pick < 88) begin
          cap = cur_cap;
        end else if (pick < 91) begin
          cap = '0;
        end else if (pick < 96) begin
          cap = $urandom;
        end else begin
          cap = cur_cap - period;
        end
        send_capture(cap, $urandom_range(9) != 0);
      end
    end
    calm = 1'b0;
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.edge_valid, out_if.rpm_instant, out_if.sample_stored, out_if.rpm_mean};
      if (speed_q.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_MAX)
          $display("unexpected result: edge=%0b inst=%0d stored=%0b mean=%0d",
                   got.edge_valid, got.rpm_instant, got.sample_stored, got.rpm_mean);
      end else begin
        want = speed_q.pop_front();
        if (got !== want) begin
          fault_count++;
          if (fault_count <= REPORT_MAX)
            $display("mismatch: exp edge=%0b inst=%0d stored=%0b mean=%0d, %s",
                     want.edge_valid, want.rpm_instant, want.sample_stored, want.rpm_mean,
                     $sformatf("got edge=%0b inst=%0d stored=%0b mean=%0d",
                               got.edge_valid, got.rpm_instant, got.sample_stored,
                               got.rpm_mean));
        end
      end
    end
    out_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // stimulus sequence
  initial begin
    in_if.valid         <= 1'b0;
    in_if.capture_value <= '0;
    in_if.motor_on      <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.reg_index    <= '0;
    cfg_if.wdata        <= '0;
    rst_n               <= 1'b0;

    // predictor reset state
    rpm_const    = RPM_CONSTANT_RST;
    filt_factor  = FILTER_FACTOR_RST;
    prev_capture = CAPTURE_BITS'(1);
    held_speed   = '0;
    ring_idx     = '0;
    ring_sum     = '0;
    nonzero_cnt  = '0;
    for (int i = 0; i < RING_DEPTH; i++) speed_ring[i] = '0;
    fault_count  = 0;
    calm         = 1'b0;
    cur_cap      = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_edge_validity();
    test_register_extremes();
    test_filtered_mean();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: hall_tachometer_rpm_filter_unit.f
rtl/htrf_pkg.sv
rtl/htrf_if.sv
rtl/hall_tachometer_rpm_filter_unit.sv
bench/hall_tachometer_rpm_filter_unit_tb.sv
